// ===== rtl/lpff_pkg.sv =====
// lpff_pkg: shared types and codes for the length-prefixed frame FIFO.
// Used by lpff_front, lpff_back and length_prefixed_frame_fifo.
package lpff_pkg;

  localparam int LPFF_CAPACITY = 4096;
  localparam int HEADER_BYTES  = 4;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_PUSHED     = 3'd0,
    ST_REJECTED   = 3'd1,
    ST_HDR_SHORT  = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_MSG_START  = 3'd4,
    ST_MSG_BYTE   = 3'd5,
    ST_CLEARED    = 3'd6
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data;
    logic        first;
    logic [11:0] len;
  } cmd_t;

endpackage

// ===== rtl/length_prefixed_frame_fifo.sv =====
// length_prefixed_frame_fifo: top level, front queue plus back engine.
// Depends on lpff_pkg, lpff_front and lpff_back.
//
//   channel  handshake            payload
//   in_      in_valid / in_stall  action, data_byte, chunk_first, chunk_length
//   out_     out_valid/out_stall  status, out_byte, message_length, last
//
// Push, clear and short-header pops are handled in the back engine's idle
// state; a message byte pop passes through S_BYTE (registered store read); a
// header pop passes through S_HDR (four serial reads of the single store read port), then S_EVAL (the length check).
// A two-entry queue sits ahead of the engine; results wait in one register.
// Reset (rst_n low, synchronous) empties the store and queue; no clearing pass.
// out_stall holds the result and, once the queue fills, raises in_stall.
module length_prefixed_frame_fifo
  import lpff_pkg::*;
#(
  parameter int CAPACITY = LPFF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_first,
  input  logic [11:0] in_chunk_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_byte,
  output logic [11:0] out_message_length,
  output logic        out_last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  lpff_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .in_chunk_first  (in_chunk_first),
    .in_chunk_length (in_chunk_length),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take)
  );

  lpff_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_take           (cmd_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_byte           (out_byte),
    .out_message_length (out_message_length),
    .out_last           (out_last)
  );

endmodule

// ===== rtl/lpff_front.sv =====
// lpff_front: accepts input items, drops the unused action code and
// queues commands in a two-entry queue. Depends on lpff_pkg.
module lpff_front
  import lpff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_chunk_first,
  input  logic [11:0] in_chunk_length,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    in_cmd.action = action_t'(in_action);
    in_cmd.data   = in_data_byte;
    in_cmd.first  = in_chunk_first;
    in_cmd.len    = in_chunk_length;
  end

  assign push = in_valid && !in_stall && (action_t'(in_action) != ACT_NONE);
  assign pop  = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop from empty queue");

  property p_cnt_step;
    @(posedge clk) disable iff (!rst_n) push && !pop |=> cnt_r == $past(cnt_r) + 2'd1;
  endproperty
  a_cnt_step: assert property (p_cnt_step) else $error("queue count slip");

  property p_never_over;
    @(posedge clk) disable iff (!rst_n) cnt_r != 2'd3;
  endproperty
  a_never_over: assert property (p_never_over) else $error("queue overflow");

endmodule

// ===== rtl/lpff_back.sv =====
// lpff_back: executes queued commands against the circular byte store,
// parses length headers and holds the result register. Depends on lpff_pkg.
module lpff_back
  import lpff_pkg::*;
#(
  parameter int CAPACITY = LPFF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_byte,
  output logic [11:0] out_message_length,
  output logic        out_last
);

  localparam int PW = $clog2(CAPACITY);
  localparam logic [PW:0]   CAP_W   = (PW+1)'(CAPACITY);
  localparam logic [PW-1:0] CAP_M1  = PW'(CAPACITY - 1);
  localparam logic [PW-1:0] HDR_W   = PW'(HEADER_BYTES);
  localparam logic [2:0]    HDR_CNT = 3'(HEADER_BYTES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BYTE = 4'b0010,
    S_HDR  = 4'b0100,
    S_EVAL = 4'b1000
  } state_t;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [2:0] k);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(k);
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[PW-1:0];
  endfunction

  logic [7:0]    mem [CAPACITY];
  logic [7:0]    rd_data_r;

  state_t        state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [11:0]   chunk_rem_r, chunk_rem_nxt;
  logic          chunk_rej_r, chunk_rej_nxt;
  logic [PW-1:0] msg_rem_r, msg_rem_nxt;
  logic          in_msg_r, in_msg_nxt;
  logic          byte_last_r, byte_last_nxt;
  logic [2:0]    hdr_idx_r, hdr_idx_nxt;
  logic [31:0]   hdr_r, hdr_nxt;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_byte_r;
  logic [11:0]   out_len_r;
  logic          out_last_r;

  logic [PW-1:0] fill;
  logic [PW-1:0] free_sp;
  logic          slot_free;
  logic          wr_en;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          emit;
  status_t       em_status;
  logic [7:0]    em_byte;
  logic [11:0]   em_len;
  logic          em_last;

  assign fill      = (wp_r >= rp_r) ? (wp_r - rp_r) : (PW'(CAPACITY) - rp_r + wp_r);
  assign free_sp   = CAP_M1 - fill;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    chunk_rem_nxt = chunk_rem_r;
    chunk_rej_nxt = chunk_rej_r;
    msg_rem_nxt   = msg_rem_r;
    in_msg_nxt    = in_msg_r;
    byte_last_nxt = byte_last_r;
    hdr_idx_nxt   = hdr_idx_r;
    hdr_nxt       = hdr_r;
    cmd_take      = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = rp_r;
    emit          = 1'b0;
    em_status     = ST_PUSHED;
    em_byte       = 8'd0;
    em_len        = 12'd0;
    em_last       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_take = 1'b1;
          case (cmd.action)
            ACT_PUSH: begin
              emit      = 1'b1;
              em_status = ST_REJECTED;
              if (cmd.first) begin
                if (cmd.len == 12'd0) begin
                  chunk_rem_nxt = 12'd0;
                  chunk_rej_nxt = 1'b0;
                end else begin
                  chunk_rem_nxt = cmd.len - 12'd1;
                  if (32'(cmd.len) > 32'(free_sp)) begin
                    chunk_rej_nxt = 1'b1;
                  end else begin
                    chunk_rej_nxt = 1'b0;
                    wr_en         = 1'b1;
                    wp_nxt        = wrap_add(wp_r, 3'd1);
                    em_status     = ST_PUSHED;
                  end
                end
              end else if (chunk_rem_r != 12'd0) begin
                chunk_rem_nxt = chunk_rem_r - 12'd1;
                if (!chunk_rej_r && free_sp != '0) begin
                  wr_en     = 1'b1;
                  wp_nxt    = wrap_add(wp_r, 3'd1);
                  em_status = ST_PUSHED;
                end
              end
            end
            ACT_POP: begin
              if (in_msg_r) begin
                if (fill == '0 || msg_rem_r == '0) begin
                  in_msg_nxt  = 1'b0;
                  msg_rem_nxt = '0;
                  emit        = 1'b1;
                  em_status   = ST_INCOMPLETE;
                end else begin
                  rd_en         = 1'b1;
                  rp_nxt        = wrap_add(rp_r, 3'd1);
                  msg_rem_nxt   = msg_rem_r - PW'(1);
                  in_msg_nxt    = (msg_rem_r != PW'(1));
                  byte_last_nxt = (msg_rem_r == PW'(1));
                  state_nxt     = S_BYTE;
                end
              end else if (fill < HDR_W) begin
                emit      = 1'b1;
                em_status = ST_HDR_SHORT;
              end else begin
                rd_en       = 1'b1;
                hdr_idx_nxt = 3'd1;
                state_nxt   = S_HDR;
              end
            end
            ACT_CLEAR: begin
              wp_nxt        = '0;
              rp_nxt        = '0;
              chunk_rem_nxt = 12'd0;
              chunk_rej_nxt = 1'b0;
              msg_rem_nxt   = '0;
              in_msg_nxt    = 1'b0;
              emit          = 1'b1;
              em_status     = ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          emit      = 1'b1;
          em_status = ST_MSG_BYTE;
          em_byte   = rd_data_r;
          em_last   = byte_last_r;
          state_nxt = S_IDLE;
        end
      end
      S_HDR: begin
        hdr_nxt = {rd_data_r, hdr_r[31:8]};
        if (hdr_idx_r != HDR_CNT) begin
          rd_en       = 1'b1;
          rd_addr     = wrap_add(rp_r, hdr_idx_r);
          hdr_idx_nxt = hdr_idx_r + 3'd1;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (hdr_r > 32'(fill - HDR_W)) begin
            em_status = ST_INCOMPLETE;
          end else begin
            rp_nxt      = wrap_add(rp_r, HDR_CNT);
            msg_rem_nxt = hdr_r[PW-1:0];
            in_msg_nxt  = (hdr_r != 32'd0);
            em_status   = ST_MSG_START;
            em_len      = hdr_r[11:0];
            em_last     = (hdr_r == 32'd0);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      chunk_rem_r <= 12'd0;
      chunk_rej_r <= 1'b0;
      msg_rem_r   <= '0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      chunk_rem_r <= chunk_rem_nxt;
      chunk_rej_r <= chunk_rej_nxt;
      msg_rem_r   <= msg_rem_nxt;
      in_msg_r    <= in_msg_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_last_r <= byte_last_nxt;
    hdr_idx_r   <= hdr_idx_nxt;
    hdr_r       <= hdr_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_byte_r   <= em_byte;
      out_len_r    <= em_len;
      out_last_r   <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_byte           = out_byte_r;
  assign out_message_length = out_len_r;
  assign out_last           = out_last_r;

  property p_msg_has_bytes;
    @(posedge clk) disable iff (!rst_n) in_msg_r |-> msg_rem_r != '0;
  endproperty
  a_msg_has_bytes: assert property (p_msg_has_bytes) else $error("message open with none left");

  property p_take_idle;
    @(posedge clk) disable iff (!rst_n) cmd_take |-> state_r == S_IDLE;
  endproperty
  a_take_idle: assert property (p_take_idle) else $error("command taken mid-operation");

  property p_eval_after_hdr;
    @(posedge clk) disable iff (!rst_n)
      state_r == S_EVAL |-> $past(state_r) == S_HDR || $past(state_r) == S_EVAL;
  endproperty
  a_eval_after_hdr: assert property (p_eval_after_hdr) else $error("header check out of order");

  property p_no_overwrite;
    @(posedge clk) disable iff (!rst_n) emit |-> slot_free;
  endproperty
  a_no_overwrite: assert property (p_no_overwrite) else $error("result overwritten");

endmodule

// ===== tb/tb_length_prefixed_frame_fifo.sv =====
// tb_length_prefixed_frame_fifo: self-checking bench for the length-prefixed frame FIFO.
// Drives push/pop/clear items through the in_ channel and checks every out_ item
// against an in-bench shadow of the store. Depends on lpff_pkg and length_prefixed_frame_fifo.
module tb_length_prefixed_frame_fifo;
  import lpff_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000; // longest quiet stretch is two of the longest gaps plus a header pop
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 1310;
  localparam int BIG_PAYLOAD    = 300;
  localparam int BIG_FRAME      = BIG_PAYLOAD + HEADER_BYTES;
  localparam int SPARE_AFTER    = LPFF_CAPACITY - 1 - BIG_FRAME;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic [11:0] msg_len;
    logic        last;
  } frame_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_data_byte;
  logic        in_chunk_first;
  logic [11:0] in_chunk_length;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [7:0]  out_byte;
  logic [11:0] out_message_length;
  logic        out_last;

  // shadow of the block
  logic [7:0] shadow_mem [LPFF_CAPACITY];
  int         shadow_wr      = 0;
  int         shadow_rd      = 0;
  int         chunk_left     = 0;
  bit         chunk_dropping = 1'b0;
  int         msg_left       = 0;
  bit         msg_open       = 1'b0;

  frame_result_t pending_results [$];
  logic [7:0]    frame_q [$];
  int            errors      = 0;
  int            items_sent  = 0;
  int            idle_cycles = 0;
  bit            calm        = 1'b0;

  length_prefixed_frame_fifo #(.CAPACITY(LPFF_CAPACITY)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_data_byte       (in_data_byte),
    .in_chunk_first     (in_chunk_first),
    .in_chunk_length    (in_chunk_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_byte           (out_byte),
    .out_message_length (out_message_length),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void frame_fifo_predict(input action_t act, input logic [7:0] data,
                                             input logic first, input logic [11:0] len);
    frame_result_t r;
    int            fill;
    int            room;
    int            i;
    logic [31:0]   hdr;
    r.status  = ST_REJECTED;
    r.data    = 8'd0;
    r.msg_len = 12'd0;
    r.last    = 1'b0;
    hdr       = 32'd0;
    fill = (shadow_wr - shadow_rd + LPFF_CAPACITY) % LPFF_CAPACITY;
    room = LPFF_CAPACITY - 1 - fill;
    case (act)
      ACT_PUSH: begin
        if (first) begin
          chunk_left     = 0;
          chunk_dropping = 1'b0;
          if (len != 12'd0) begin
            chunk_left = int'(len) - 1;
            if (int'(len) > room) begin
              chunk_dropping = 1'b1;
            end else begin
              shadow_mem[shadow_wr] = data;
              shadow_wr = (shadow_wr + 1) % LPFF_CAPACITY;
              r.status  = ST_PUSHED;
            end
          end
        end else if (chunk_left != 0) begin
          chunk_left--;
          if (!chunk_dropping && room != 0) begin
            shadow_mem[shadow_wr] = data;
            shadow_wr = (shadow_wr + 1) % LPFF_CAPACITY;
            r.status  = ST_PUSHED;
          end
        end
      end
      ACT_POP: begin
        if (msg_open) begin
          if (fill == 0 || msg_left == 0) begin
            msg_open = 1'b0;
            msg_left = 0;
            r.status = ST_INCOMPLETE;
          end else begin
            r.data    = shadow_mem[shadow_rd];
            shadow_rd = (shadow_rd + 1) % LPFF_CAPACITY;
            msg_left--;
            msg_open  = (msg_left != 0);
            r.status  = ST_MSG_BYTE;
            r.last    = (msg_left == 0);
          end
        end else if (fill < HEADER_BYTES) begin
          r.status = ST_HDR_SHORT;
        end else begin
          for (i = 0; i < HEADER_BYTES; i++)
            hdr[8*i +: 8] = shadow_mem[(shadow_rd + i) % LPFF_CAPACITY];
          if (hdr > 32'(fill - HEADER_BYTES)) begin
            r.status = ST_INCOMPLETE;
          end else begin
            shadow_rd = (shadow_rd + HEADER_BYTES) % LPFF_CAPACITY;
            msg_left  = int'(hdr);
            msg_open  = (hdr != 32'd0);
            r.status  = ST_MSG_START;
            r.msg_len = hdr[11:0];
            r.last    = (hdr == 32'd0);
          end
        end
      end
      ACT_CLEAR: begin
        shadow_wr      = 0;
        shadow_rd      = 0;
        chunk_left     = 0;
        chunk_dropping = 1'b0;
        msg_left       = 0;
        msg_open       = 1'b0;
        r.status       = ST_CLEARED;
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic send_item(input action_t act, input logic [7:0] data,
                           input logic first, input logic [11:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_data_byte    <= data;
    in_chunk_first  <= first;
    in_chunk_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_fifo_predict(act, data, first, len);
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic pop_n(input int n);
    repeat (n) send_item(ACT_POP, 8'($urandom), 1'($urandom), 12'($urandom));
  endtask

  // header (little-endian payload length) followed by a random payload
  task automatic build_frame(input int plen);
    logic [31:0] hdr;
    int          i;
    hdr = 32'(plen);
    frame_q.delete();
    for (i = 0; i < HEADER_BYTES; i++) frame_q.push_back(hdr[8*i +: 8]);
    repeat (plen) frame_q.push_back(8'($urandom));
  endtask

  // declared of zero sends continuation bytes only
  task automatic push_bytes(input int start_idx, input int count, input int declared,
                            input bit mid_pops);
    int  i;
    bit  opens;
    for (i = 0; i < count; i++) begin
      if (mid_pops && $urandom_range(0, 39) == 0) pop_n(1);
      opens = (i == 0 && declared != 0);
      send_item(ACT_PUSH, frame_q[start_idx + i], opens,
                opens ? 12'(declared) : 12'($urandom));
    end
  endtask

  task automatic test_empty_and_stray();
    pop_n(1);
    send_item(ACT_PUSH, 8'hFF, 1'b0, 12'hFFF);
    send_item(ACT_PUSH, 8'h00, 1'b1, 12'd0);
  endtask

  task automatic test_single_frame();
    frame_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    push_bytes(0, 3, 6, 1'b0);
    pop_n(1);
    push_bytes(3, 2, 0, 1'b0);
    pop_n(1);
    push_bytes(5, 1, 0, 1'b0);
    pop_n(4);
  endtask

  task automatic test_zero_length_frame();
    build_frame(0);
    push_bytes(0, HEADER_BYTES, HEADER_BYTES, 1'b0);
    pop_n(1);
  endtask

  task automatic test_chunk_rules();
    send_item(ACT_PUSH, 8'h11, 1'b1, 12'd10);
    send_item(ACT_PUSH, 8'h22, 1'b1, 12'd4095);
    send_item(ACT_PUSH, 8'h33, 1'b0, 12'd0);
    send_item(ACT_NONE, 8'hA5, 1'b1, 12'hABC);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 12'd0);
    send_item(ACT_PUSH, 8'h44, 1'b1, 12'd4095);
    send_item(ACT_CLEAR, 8'hFF, 1'b1, 12'hFFF);
  endtask

  // large frame, then chunks one past and exactly at the remaining free space
  task automatic test_large_frame();
    send_item(ACT_CLEAR, 8'h00, 1'b0, 12'd0);
    build_frame(BIG_PAYLOAD);
    push_bytes(0, BIG_FRAME, BIG_FRAME, 1'b0);
    send_item(ACT_PUSH, 8'($urandom), 1'b1, 12'(SPARE_AFTER + 1));
    send_item(ACT_PUSH, 8'($urandom), 1'b0, 12'($urandom));
    send_item(ACT_PUSH, 8'($urandom), 1'b1, 12'(SPARE_AFTER));
    pop_n(BIG_PAYLOAD + 1 + 1);
    send_item(ACT_CLEAR, 8'h00, 1'b0, 12'd0);
  endtask

  task automatic test_random_traffic();
    int target;
    int next_flip;
    int owed;
    int plen;
    int cut;
    int n;
    int r;
    target    = items_sent + RANDOM_ITEMS;
    next_flip = items_sent;
    owed      = 0;
    while (items_sent < target) begin
      if (items_sent >= next_flip) begin
        calm      = ($urandom_range(0, 2) == 0);
        next_flip = items_sent + 150;
      end
      r = $urandom_range(0, 99);
      if (r < 65) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
        build_frame(plen);
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, plen + HEADER_BYTES - 1);
          push_bytes(0, cut, cut, 1'b1);
          push_bytes(cut, plen + HEADER_BYTES - cut, plen + HEADER_BYTES - cut, 1'b1);
        end else begin
          push_bytes(0, plen + HEADER_BYTES, plen + HEADER_BYTES, 1'b1);
        end
        owed += plen + 1;
        if (owed > 400 || $urandom_range(0, 2) == 0) begin
          n = (owed > 400) ? owed : $urandom_range(0, owed + 1);
          pop_n(n);
          owed = (n >= owed) ? 0 : owed - n;
        end
      end else begin
        case ($urandom_range(0, 6))
          0: send_item(ACT_PUSH, 8'($urandom), 1'b0, 12'($urandom));
          1: send_item(ACT_PUSH, 8'($urandom), 1'b1, 12'd0);
          2: begin
            send_item(ACT_PUSH, 8'($urandom), 1'b1, 12'($urandom));
            repeat ($urandom_range(0, 3))
              send_item(ACT_PUSH, 8'($urandom), 1'b0, 12'($urandom));
            if ($urandom_range(0, 1) == 0) begin
              send_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
              owed = 0;
            end
          end
          3: begin
            send_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
            owed = 0;
          end
          4: send_item(ACT_NONE, 8'($urandom), 1'($urandom), 12'($urandom));
          5: pop_n($urandom_range(1, 3));
          default: begin
            // frame cut short of its declared length
            plen = $urandom_range(1, 20);
            build_frame(plen);
            push_bytes(0, $urandom_range(1, plen + HEADER_BYTES - 1), plen + HEADER_BYTES, 1'b0);
            pop_n($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 0) begin
              send_item(ACT_CLEAR, 8'($urandom), 1'($urandom), 12'($urandom));
              owed = 0;
            end
          end
        endcase
      end
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_length_prefixed_frame_fifo passed");
    end else begin
      $display("tb_length_prefixed_frame_fifo failed");
    end
    $finish;
  endtask

  initial begin : out_stall_gen
    int run;
    int hold;
    out_stall <= 1'b0;
    forever begin
      run = $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: out_status %0d", out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("out_status expected %0d actual %0d", want.status, out_status);
          errors++;
        end
        if (out_byte !== want.data) begin
          $error("out_byte expected %0h actual %0h", want.data, out_byte);
          errors++;
        end
        if (out_message_length !== want.msg_len) begin
          $error("out_message_length expected %0d actual %0d", want.msg_len,
                 out_message_length);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %0b actual %0b", want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_length_prefixed_frame_fifo failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_action       <= ACT_NONE;
    in_data_byte    <= 8'd0;
    in_chunk_first  <= 1'b0;
    in_chunk_length <= 12'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_stray();
    test_single_frame();
    test_zero_length_frame();
    test_chunk_rules();
    test_large_frame();
    test_random_traffic();
    finish_run();
  end

endmodule
